/* rtl/obox_pkg.sv */
// obox_pkg: constants and codes shared by the oriented box overlap pipeline
// no dependencies
package obox_pkg;

  // heading decoding
  localparam int          HEADING_W  = 16;
  localparam int          RES_W      = 14;
  localparam logic [14:0] QUARTER    = 15'd16384;

  // heading quadrant codes
  localparam logic [1:0]  QUAD_0     = 2'd0;
  localparam logic [1:0]  QUAD_1     = 2'd1;
  localparam logic [1:0]  QUAD_2     = 2'd2;
  localparam logic [1:0]  QUAD_3     = 2'd3;

  // quarter-wave sine polynomial coefficients, Q30
  localparam logic [30:0] POLY_A     = 31'd1686629713;
  localparam logic [29:0] POLY_B     = 30'd693598668;
  localparam logic [26:0] POLY_C     = 27'd80710779;

  // field widths
  localparam int          COORD_W    = 32;
  localparam int          DELTA_W    = 33;
  localparam int          SIZE_W     = 16;

endpackage

/* rtl/obox_in_if.sv */
// obox_in_if: input channel carrying one box pair per beat
// depends on nothing
interface obox_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_center_x;
  logic signed [31:0] first_center_y;
  logic [15:0]        first_heading;
  logic [15:0]        first_length;
  logic [15:0]        first_width;
  logic signed [31:0] second_center_x;
  logic signed [31:0] second_center_y;
  logic [15:0]        second_heading;
  logic [15:0]        second_length;
  logic [15:0]        second_width;

  modport source (output valid, first_center_x, first_center_y, first_heading,
                  first_length, first_width, second_center_x, second_center_y,
                  second_heading, second_length, second_width, input ready);
  modport sink   (input valid, first_center_x, first_center_y, first_heading,
                  first_length, first_width, second_center_x, second_center_y,
                  second_heading, second_length, second_width, output ready);
endinterface

/* rtl/obox_out_if.sv */
// obox_out_if: result channel carrying one overlap flag per beat
// depends on nothing
interface obox_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink   (input valid, overlap, output ready);
endinterface

/* rtl/obox_trig.sv */
// obox_trig: five-stage cosine/sine unit for one heading, quarter-wave polynomial
// depends on obox_pkg
module obox_trig
  import obox_pkg::*;
#(
  parameter int FRAC = 15
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [HEADING_W-1:0]   heading,
  output logic signed [FRAC+1:0] cos_o,
  output logic signed [FRAC+1:0] sin_o
);

  localparam int          TW   = FRAC + 2;
  localparam int          SH   = 30 - FRAC;
  localparam logic [31:0] HALF = (32'd1 << SH) >> 1;

  // lane 0 evaluates q(r), lane 1 evaluates q(quarter - r)
  logic [14:0]  arg [2];
  logic [30:0]  xa_r [2];
  logic [30:0]  x2a_r [2];
  logic [30:0]  xb_r [2];
  logic [30:0]  x2b_r [2];
  logic [29:0]  tb_r [2];
  logic [30:0]  xc_r [2];
  logic [30:0]  tc_r [2];
  logic [30:0]  qd_r [2];
  logic [1:0]   quad_r [4];
  logic [61:0]  sq_prod [2];
  logic [57:0]  c_prod [2];
  logic [60:0]  t_prod [2];
  logic [61:0]  q_prod [2];
  logic [31:0]  rnd [2];
  logic [31:0]  shf [2];
  logic signed [TW-1:0] mag [2];
  logic signed [TW-1:0] cos_nxt;
  logic signed [TW-1:0] sin_nxt;

  assign arg[0] = {1'b0, heading[RES_W-1:0]};
  assign arg[1] = QUARTER - {1'b0, heading[RES_W-1:0]};

  // polynomial products, one multiplier per lane and stage
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sq_prod[i] = {arg[i], 16'd0} * {arg[i], 16'd0};
      c_prod[i]  = 58'(x2a_r[i]) * 58'(POLY_C);
      t_prod[i]  = 61'(x2b_r[i]) * 61'(tb_r[i]);
      q_prod[i]  = 62'(xc_r[i]) * 62'(tc_r[i]);
      rnd[i]     = 32'(qd_r[i]) + HALF;
      shf[i]     = rnd[i] >> SH;
      mag[i]     = TW'({1'b0, shf[i][FRAC:0]});
    end
  end

  // quadrant folding
  always_comb begin
    unique case (quad_r[3])
      QUAD_0: begin
        sin_nxt = mag[0];
        cos_nxt = mag[1];
      end
      QUAD_1: begin
        sin_nxt = mag[1];
        cos_nxt = -mag[0];
      end
      QUAD_2: begin
        sin_nxt = -mag[0];
        cos_nxt = -mag[1];
      end
      default: begin
        sin_nxt = -mag[1];
        cos_nxt = mag[0];
      end
    endcase
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        xa_r[i]  <= {arg[i], 16'd0};
        x2a_r[i] <= sq_prod[i][60:30];
        xb_r[i]  <= xa_r[i];
        x2b_r[i] <= x2a_r[i];
        tb_r[i]  <= POLY_B - 30'(c_prod[i][56:30]);
        xc_r[i]  <= xb_r[i];
        tc_r[i]  <= POLY_A - t_prod[i][60:30];
        qd_r[i]  <= q_prod[i][60:30];
      end
      quad_r[0] <= heading[HEADING_W-1:RES_W];
      for (int k = 1; k < 4; k++) begin
        quad_r[k] <= quad_r[k-1];
      end
      cos_o <= cos_nxt;
      sin_o <= sin_nxt;
    end
  end

endmodule

/* rtl/obox_proj.sv */
// obox_proj: three-stage projection of axes and center offset
// depends on obox_pkg
module obox_proj
  import obox_pkg::*;
#(
  parameter int FRAC = 15
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [DELTA_W-1:0]     dx,
  input  logic signed [DELTA_W-1:0]     dy,
  input  logic signed [FRAC+1:0]        c1,
  input  logic signed [FRAC+1:0]        s1,
  input  logic signed [FRAC+1:0]        c2,
  input  logic signed [FRAC+1:0]        s2,
  output logic [FRAC+1:0]               rn1_o,
  output logic [FRAC+1:0]               rn2_o,
  output logic [FRAC+1:0]               rp_o,
  output logic [FRAC+1:0]               rq_o,
  output logic [DELTA_W+FRAC+2:0]       gap2_o [4]
);

  localparam int TW = FRAC + 2;
  localparam int PW = 2 * TW;
  localparam int DW = PW + 1;
  localparam int GP = DELTA_W + TW;
  localparam int GW = GP + 1;
  localparam int RW = FRAC + 2;
  localparam logic [DW-1:0] HALF_F = DW'(1) << (FRAC - 1);

  logic signed [PW-1:0] tp_r [8];
  logic signed [GP-1:0] gp_r [8];
  logic signed [DW-1:0] dot_r [4];
  logic signed [GW-1:0] g_r [4];
  logic [DW-1:0]        dmag [4];
  logic [DW-1:0]        drnd [4];
  logic [GW-1:0]        gmag [4];

  // stage one: products
  always_ff @(posedge clk) begin
    if (en) begin
      tp_r[0] <= c1 * c1;
      tp_r[1] <= s1 * s1;
      tp_r[2] <= c2 * c2;
      tp_r[3] <= s2 * s2;
      tp_r[4] <= c1 * c2;
      tp_r[5] <= s1 * s2;
      tp_r[6] <= c1 * s2;
      tp_r[7] <= s1 * c2;
      gp_r[0] <= dx * c1;
      gp_r[1] <= dy * s1;
      gp_r[2] <= dy * c1;
      gp_r[3] <= dx * s1;
      gp_r[4] <= dx * c2;
      gp_r[5] <= dy * s2;
      gp_r[6] <= dy * c2;
      gp_r[7] <= dx * s2;
    end
  end

  // stage two: dot product sums
  always_ff @(posedge clk) begin
    if (en) begin
      dot_r[0] <= DW'(tp_r[0]) + DW'(tp_r[1]);
      dot_r[1] <= DW'(tp_r[2]) + DW'(tp_r[3]);
      dot_r[2] <= DW'(tp_r[4]) + DW'(tp_r[5]);
      dot_r[3] <= DW'(tp_r[6]) - DW'(tp_r[7]);
      g_r[0]   <= GW'(gp_r[0]) + GW'(gp_r[1]);
      g_r[1]   <= GW'(gp_r[2]) - GW'(gp_r[3]);
      g_r[2]   <= GW'(gp_r[4]) + GW'(gp_r[5]);
      g_r[3]   <= GW'(gp_r[6]) - GW'(gp_r[7]);
    end
  end

  // magnitudes and rounding to the trig fraction
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dmag[i] = dot_r[i][DW-1] ? DW'(-dot_r[i]) : DW'(dot_r[i]);
      drnd[i] = dmag[i] + HALF_F;
      gmag[i] = g_r[i][GW-1] ? GW'(-g_r[i]) : GW'(g_r[i]);
    end
  end

  // stage three
  always_ff @(posedge clk) begin
    if (en) begin
      rn1_o <= drnd[0][FRAC+RW-1:FRAC];
      rn2_o <= drnd[1][FRAC+RW-1:FRAC];
      rp_o  <= drnd[2][FRAC+RW-1:FRAC];
      rq_o  <= drnd[3][FRAC+RW-1:FRAC];
      for (int i = 0; i < 4; i++) begin
        // magnitude never reaches the top bit, so doubling fits the port
        gap2_o[i] <= {gmag[i][GW-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/obox_cmp.sv */
// obox_cmp: three-stage extent sum and separating axis decision
// depends on obox_pkg
module obox_cmp
  import obox_pkg::*;
#(
  parameter int FRAC = 15
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [SIZE_W-1:0]           l1,
  input  logic [SIZE_W-1:0]           w1,
  input  logic [SIZE_W-1:0]           l2,
  input  logic [SIZE_W-1:0]           w2,
  input  logic [FRAC+1:0]             rn1,
  input  logic [FRAC+1:0]             rn2,
  input  logic [FRAC+1:0]             rp,
  input  logic [FRAC+1:0]             rq,
  input  logic [DELTA_W+FRAC+2:0]     gap2 [4],
  output logic                        overlap_o
);

  localparam int RW  = FRAC + 2;
  localparam int EW  = SIZE_W + RW;
  localparam int SW  = EW + 2;
  localparam int G2W = DELTA_W + FRAC + 3;

  logic [EW-1:0]  ep_r [12];
  logic [SW-1:0]  ext_r [4];
  logic [G2W-1:0] gap_a_r [4];
  logic [G2W-1:0] gap_b_r [4];
  logic [3:0]     sep;

  // stage one: size times projected unit length
  always_ff @(posedge clk) begin
    if (en) begin
      ep_r[0]  <= EW'(l1) * EW'(rn1);
      ep_r[1]  <= EW'(l2) * EW'(rp);
      ep_r[2]  <= EW'(w2) * EW'(rq);
      ep_r[3]  <= EW'(w1) * EW'(rn1);
      ep_r[4]  <= EW'(l2) * EW'(rq);
      ep_r[5]  <= EW'(w2) * EW'(rp);
      ep_r[6]  <= EW'(l1) * EW'(rp);
      ep_r[7]  <= EW'(w1) * EW'(rq);
      ep_r[8]  <= EW'(l2) * EW'(rn2);
      ep_r[9]  <= EW'(l1) * EW'(rq);
      ep_r[10] <= EW'(w1) * EW'(rp);
      ep_r[11] <= EW'(w2) * EW'(rn2);
      gap_a_r  <= gap2;
    end
  end

  // stage two: extent per axis
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        ext_r[i] <= SW'(ep_r[3*i]) + SW'(ep_r[3*i+1]) + SW'(ep_r[3*i+2]);
      end
      gap_b_r <= gap_a_r;
    end
  end

  // strict gap beyond extent separates the boxes
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sep[i] = gap_b_r[i] > G2W'(ext_r[i]);
    end
  end

  // stage three: result register
  always_ff @(posedge clk) begin
    if (en) begin
      overlap_o <= ~(|sep);
    end
  end

endmodule

/* rtl/oriented_box_overlap_test.sv */
// oriented_box_overlap_test: each accepted input beat gives one result beat;
// throughput one box pair per cycle with no stall.
// the path runs through the 5-stage polynomial trig unit, 3 projection stages
// and 3 extent/compare stages after the input register.
// rst_n synchronously clears the stage valid bits; data registers keep no reset.
// a stalled result holds the whole pipeline, nothing is dropped or repeated.
module oriented_box_overlap_test
  import obox_pkg::*;
#(
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  logic      clk,
  input  logic      rst_n,
  obox_in_if.sink   in_chan,
  obox_out_if.source out_chan
);

  localparam int FRAC   = TRIG_FRACTION_BITS;
  localparam int TW     = FRAC + 2;
  localparam int STAGES = 12;
  localparam int D_DLY  = 5;
  localparam int S_DLY  = 8;

  logic                       en;
  logic [STAGES-1:0]          vld_r;
  logic [STAGES-1:0]          vld_nxt;
  logic signed [DELTA_W-1:0]  dx_r [D_DLY+1];
  logic signed [DELTA_W-1:0]  dy_r [D_DLY+1];
  logic [HEADING_W-1:0]       h1_r;
  logic [HEADING_W-1:0]       h2_r;
  logic [SIZE_W-1:0]          l1_r [S_DLY+1];
  logic [SIZE_W-1:0]          w1_r [S_DLY+1];
  logic [SIZE_W-1:0]          l2_r [S_DLY+1];
  logic [SIZE_W-1:0]          w2_r [S_DLY+1];
  logic signed [TW-1:0]       c1;
  logic signed [TW-1:0]       s1;
  logic signed [TW-1:0]       c2;
  logic signed [TW-1:0]       s2;
  logic [FRAC+1:0]            rn1;
  logic [FRAC+1:0]            rn2;
  logic [FRAC+1:0]            rp;
  logic [FRAC+1:0]            rq;
  logic [DELTA_W+FRAC+2:0]    gap2 [4];
  logic                       overlap;

  // pipeline advances unless the result beat is held
  assign en              = ~vld_r[STAGES-1] | out_chan.ready;
  assign in_chan.ready   = en;
  assign out_chan.valid  = vld_r[STAGES-1];
  assign out_chan.overlap = overlap;
  assign vld_nxt         = {vld_r[STAGES-2:0], in_chan.valid};

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // input stage and side-band delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r[0] <= DELTA_W'(in_chan.second_center_x) - DELTA_W'(in_chan.first_center_x);
      dy_r[0] <= DELTA_W'(in_chan.second_center_y) - DELTA_W'(in_chan.first_center_y);
      h1_r    <= in_chan.first_heading;
      h2_r    <= in_chan.second_heading;
      l1_r[0] <= in_chan.first_length;
      w1_r[0] <= in_chan.first_width;
      l2_r[0] <= in_chan.second_length;
      w2_r[0] <= in_chan.second_width;
      for (int k = 1; k <= D_DLY; k++) begin
        dx_r[k] <= dx_r[k-1];
        dy_r[k] <= dy_r[k-1];
      end
      for (int k = 1; k <= S_DLY; k++) begin
        l1_r[k] <= l1_r[k-1];
        w1_r[k] <= w1_r[k-1];
        l2_r[k] <= l2_r[k-1];
        w2_r[k] <= w2_r[k-1];
      end
    end
  end

  // heading trig for each box
  obox_trig #(.FRAC(FRAC)) u_trig1 (
    .clk     (clk),
    .en      (en),
    .heading (h1_r),
    .cos_o   (c1),
    .sin_o   (s1)
  );

  obox_trig #(.FRAC(FRAC)) u_trig2 (
    .clk     (clk),
    .en      (en),
    .heading (h2_r),
    .cos_o   (c2),
    .sin_o   (s2)
  );

  // projections onto the four axes
  obox_proj #(.FRAC(FRAC)) u_proj (
    .clk    (clk),
    .en     (en),
    .dx     (dx_r[D_DLY]),
    .dy     (dy_r[D_DLY]),
    .c1     (c1),
    .s1     (s1),
    .c2     (c2),
    .s2     (s2),
    .rn1_o  (rn1),
    .rn2_o  (rn2),
    .rp_o   (rp),
    .rq_o   (rq),
    .gap2_o (gap2)
  );

  // extents and decision
  obox_cmp #(.FRAC(FRAC)) u_cmp (
    .clk       (clk),
    .en        (en),
    .l1        (l1_r[S_DLY]),
    .w1        (w1_r[S_DLY]),
    .l2        (l2_r[S_DLY]),
    .w2        (w2_r[S_DLY]),
    .rn1       (rn1),
    .rn2       (rn2),
    .rp        (rp),
    .rq        (rq),
    .gap2      (gap2),
    .overlap_o (overlap)
  );

endmodule

/* rtl/obox_checker.sv */
// obox_checker: port-level assertions for the oriented box overlap test
// bound to oriented_box_overlap_test, depends on its channel interfaces
module obox_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_overlap
);

  // a held result beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_overlap))
    else $error("result beat changed while stalled");

  // input is refused only while a result beat is held
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input refused with free output");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // a stalled output stalls the input too
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while pipeline held");

endmodule

bind oriented_box_overlap_test obox_checker u_obox_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_overlap (out_chan.overlap)
);

/* sim/oriented_box_overlap_checker.sv */
// oriented_box_overlap_checker: watches the box pair and result channels,
// predicts each overlap flag and compares it; depends on obox_pkg, obox_in_if, obox_out_if
`timescale 1ns / 100ps

module oriented_box_overlap_checker
  import obox_pkg::*;
#(
  parameter int TRIG_FRACTION_BITS = 15
) (
  input  logic   clk,
  input  logic   rst_n,
  obox_in_if     in_mon,
  obox_out_if    out_mon,
  output int     fail_count,
  output int     pending_count
);

  localparam longint unsigned COEF_A = 64'd1686629713;
  localparam longint unsigned COEF_B = 64'd693598668;
  localparam longint unsigned COEF_C = 64'd80710779;

  bit expected_overlaps[$];

  // quarter-wave sine of r/16384 of a quarter turn, Q30
  function automatic longint unsigned qsine(input int unsigned r);
    longint unsigned x, x2, t;
    x  = longint'(r) << 16;
    x2 = (x * x) >> 30;
    t  = COEF_B - ((x2 * COEF_C) >> 30);
    t  = COEF_A - ((x2 * t) >> 30);
    return (x * t) >> 30;
  endfunction

  function automatic longint round_trig(input longint unsigned v);
    int unsigned sh;
    sh = 30 - TRIG_FRACTION_BITS;
    if (sh > 0) v = (v + (64'd1 << (sh - 1))) >> sh;
    return longint'(v);
  endfunction

  // cosine and sine of a heading, Q(TRIG_FRACTION_BITS)
  task automatic heading_cs(input logic [15:0] h, output longint c, output longint s);
    longint a, b;
    a = round_trig(qsine(h[13:0]));
    b = round_trig(qsine(16384 - h[13:0]));
    case (h[15:14])
      QUAD_0: begin s = a;  c = b;  end
      QUAD_1: begin s = b;  c = -a; end
      QUAD_2: begin s = -a; c = -b; end
      default: begin s = -b; c = a; end
    endcase
  endtask

  function automatic longint unsigned abs_dot(input longint ax, input longint ay,
                                              input longint bx, input longint by);
    longint d;
    d = ax * bx + ay * by;
    if (d < 0) d = -d;
    return (longint'(d) + (64'd1 << (TRIG_FRACTION_BITS - 1))) >> TRIG_FRACTION_BITS;
  endfunction

  function automatic bit overlap_of(
      input longint dx, input longint dy,
      input longint c1, input longint s1, input longint l1, input longint w1,
      input longint c2, input longint s2, input longint l2, input longint w2);
    longint ax[4], ay[4];
    longint g;
    longint unsigned gap2, ext2;
    bit sep;
    ax = '{c1, -s1, c2, -s2};
    ay = '{s1, c1, s2, c2};
    sep = 0;
    for (int k = 0; k < 4; k++) begin
      g = dx * ax[k] + dy * ay[k];
      if (g < 0) g = -g;
      gap2 = longint'(g) * 2;
      ext2 = l1 * abs_dot(c1, s1, ax[k], ay[k]) + w1 * abs_dot(-s1, c1, ax[k], ay[k])
           + l2 * abs_dot(c2, s2, ax[k], ay[k]) + w2 * abs_dot(-s2, c2, ax[k], ay[k]);
      if (gap2 > ext2) sep = 1;
    end
    return !sep;
  endfunction

  assign pending_count = expected_overlaps.size();

  // predict on input beats, compare on result beats
  always @(posedge clk) begin
    longint c1, s1, c2, s2, dx, dy;
    bit want;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        heading_cs(in_mon.first_heading, c1, s1);
        heading_cs(in_mon.second_heading, c2, s2);
        dx = longint'(in_mon.second_center_x) - longint'(in_mon.first_center_x);
        dy = longint'(in_mon.second_center_y) - longint'(in_mon.first_center_y);
        expected_overlaps.push_back(overlap_of(dx, dy, c1, s1,
          in_mon.first_length, in_mon.first_width, c2, s2,
          in_mon.second_length, in_mon.second_width));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_overlaps.size() == 0) begin
          $display("%0t: unexpected result beat, overlap %0b", $time, out_mon.overlap);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_overlaps.pop_front();
          if (out_mon.overlap !== want) begin
            $display("%0t: overlap mismatch, expected %0b actual %0b",
                     $time, want, out_mon.overlap);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* sim/oriented_box_overlap_test_test.sv */
// oriented_box_overlap_test_test: drives box pairs into the overlap pipeline
// with bursty input and stalling output; depends on the rtl and the checker
`timescale 1ns / 100ps

module oriented_box_overlap_test_test;
  import obox_pkg::*;

  typedef struct packed {
    logic signed [31:0] x1, y1;
    logic [15:0]        h1, l1, w1;
    logic signed [31:0] x2, y2;
    logic [15:0]        h2, l2, w2;
  } box_pair_t;

  logic clk, rst_n;
  int   fail_count, pending_count;
  bit   hold_off;
  obox_in_if  in_chan();
  obox_out_if out_chan();

  oriented_box_overlap_test dut (.clk(clk), .rst_n(rst_n), .in_chan(in_chan),
                                 .out_chan(out_chan));
  oriented_box_overlap_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_chan),
    .out_mon(out_chan), .fail_count(fail_count), .pending_count(pending_count));

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  box_pair_t directed[$];

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 80000)) - 40000;
    endcase
  endfunction

  function automatic logic [15:0] rand_size();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 16'hffff : 16'h0;
      default: return $urandom_range(0, 12000);
    endcase
  endfunction

  function automatic box_pair_t rand_pair();
    box_pair_t p;
    p.x1 = rand_coord(); p.y1 = rand_coord();
    p.h1 = $urandom;     p.l1 = rand_size(); p.w1 = rand_size();
    p.h2 = $urandom;     p.l2 = rand_size(); p.w2 = rand_size();
    // mostly near pairs so both verdicts show up
    if ($urandom_range(0, 3) != 0 && p.x1 < 32'sh7ff00000 && p.y1 < 32'sh7ff00000) begin
      p.x2 = p.x1 + $signed($urandom_range(0, 30000)) - 15000;
      p.y2 = p.y1 + $signed($urandom_range(0, 30000)) - 15000;
    end else begin
      p.x2 = rand_coord(); p.y2 = rand_coord();
    end
    return p;
  endfunction

  task automatic send_pair(input box_pair_t p);
    in_chan.valid           <= 1'b1;
    in_chan.first_center_x  <= p.x1;
    in_chan.first_center_y  <= p.y1;
    in_chan.first_heading   <= p.h1;
    in_chan.first_length    <= p.l1;
    in_chan.first_width     <= p.w1;
    in_chan.second_center_x <= p.x2;
    in_chan.second_center_y <= p.y2;
    in_chan.second_heading  <= p.h2;
    in_chan.second_length   <= p.l2;
    in_chan.second_width    <= p.w2;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // receiver stall pattern, with one long hold-off
  initial begin
    int phase;
    out_chan.ready = 1'b0;
    phase = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_chan.ready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      phase++;
      if ((phase / 300) % 3 == 0) out_chan.ready <= 1'b1;
      else out_chan.ready <= ($urandom_range(0, 3) != 0);
      @(posedge clk);
    end
  end

  initial begin
    box_pair_t p;
    int burst, wait_cycles;
    bit pressed;
    in_chan.valid = 0;
    in_chan.first_center_x = 0;  in_chan.first_center_y = 0;
    in_chan.first_heading = 0;   in_chan.first_length = 0;  in_chan.first_width = 0;
    in_chan.second_center_x = 0; in_chan.second_center_y = 0;
    in_chan.second_heading = 0;  in_chan.second_length = 0; in_chan.second_width = 0;
    hold_off = 0;
    pressed = 0;
    rst_n = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: points, coincident centers, extremes, quadrant edges, touching
    directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{0, 0, 0, 0, 0, 1, 0, 0, 0, 0});
    directed.push_back('{100, 200, 16'h4000, 500, 300, 100, 200, 16'h8000, 0, 0});
    directed.push_back('{32'sh7fffffff, 32'sh7fffffff, 16'hffff, 16'hffff, 16'hffff,
                         32'sh80000000, 32'sh80000000, 16'hffff, 16'hffff, 16'hffff});
    directed.push_back('{32'sh80000000, 0, 0, 16'hffff, 16'hffff,
                         32'sh7fffffff, 0, 0, 16'hffff, 16'hffff});
    directed.push_back('{0, 0, 0, 200, 100, 200, 0, 0, 200, 100});
    directed.push_back('{0, 0, 0, 200, 100, 201, 0, 0, 200, 100});
    directed.push_back('{0, 0, 16'h4000, 200, 100, 0, 100, 16'hc000, 200, 100});
    directed.push_back('{0, 0, 16'h2000, 1000, 1000, 1400, 1400, 16'h6000, 1000, 1000});
    directed.push_back('{0, 0, 16'h3fff, 800, 80, 500, 500, 16'h4001, 800, 80});
    directed.push_back('{0, 0, 16'h7fff, 800, 80, -500, 500, 16'hbfff, 800, 80});
    directed.push_back('{-5, -5, 16'hc000, 16'hffff, 0, 5, 5, 16'h8001, 0, 16'hffff});
    directed.push_back('{1000, -1000, 16'h1234, 300, 300, 1000, -1000, 16'hedcb, 0, 0});
    foreach (directed[i]) send_pair(directed[i]);
    in_chan.valid <= 1'b0;

    // random bursts, one long receiver hold-off once 600 pairs are sent
    for (int n = 0; n < 1400;) begin
      if (n >= 600 && !pressed) begin
        hold_off = 1;
        pressed = 1;
      end
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < 1400; k++, n++) send_pair(rand_pair());
      in_chan.valid <= 1'b0;
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (wait_cycles) @(posedge clk);
    end
    in_chan.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
